/* rtl/sv39_page_table_walker_unit_defines.svh */
// Assertion macros for the Sv39 page table walker unit.
// Used by modules that carry concurrent checks; expects clock and reset in scope.
`ifndef SV39_PAGE_TABLE_WALKER_UNIT_DEFINES_SVH
`define SV39_PAGE_TABLE_WALKER_UNIT_DEFINES_SVH

// check a condition in the same cycle
`define SV39W_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// check a condition in the cycle after the antecedent
`define SV39W_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/sv39w_pkg.sv */
// Package for the Sv39 page table walker: field widths, status codes, PTE bits,
// walker state type and the result payload type. No dependencies.
`timescale 1ns / 1ps

package sv39w_pkg;

   localparam int unsigned IDX_W     = 9;
   localparam int unsigned PAGE_W    = 12;
   localparam int unsigned PPN_W     = 44;
   localparam int unsigned PA_W      = 56;
   localparam int unsigned WORD_W    = 64;
   localparam int unsigned WIDX_W    = 12;
   localparam int unsigned ROOT_W    = 3;
   localparam int unsigned STATUS_W  = 3;
   localparam int unsigned PAGE_WORDS = 512;

   localparam int unsigned PTE_V   = 0;
   localparam int unsigned PTE_U   = 4;
   localparam int unsigned PPN_LSB = 10;

   localparam logic ACT_WRITE     = 1'b0;
   localparam logic ACT_TRANSLATE = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_LIMIT   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_UPPER   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_LEAF    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_USER    = 3'd4;
   localparam logic [STATUS_W-1:0] ST_OUTSIDE = 3'd5;

   typedef enum logic [2:0] {
      WS_CLEAR,
      WS_IDLE,
      WS_L2,
      WS_L1,
      WS_L0,
      WS_HOLD
   } walk_state_type;

   typedef struct packed {
      logic [PA_W-1:0]     phys_addr;
      logic [STATUS_W-1:0] status;
   } result_type;

endpackage

/* rtl/sv39w_req_if.sv */
// Request channel interface: valid/ready handshake with write or translate item.
// Depends on nothing.
`timescale 1ns / 1ps

interface sv39w_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic [11:0] word_index;
   logic [63:0] word_data;
   logic [63:0] virt_addr;

   modport source (output valid, output action, output word_index, output word_data,
                   output virt_addr, input ready);
   modport sink (input valid, input action, input word_index, input word_data,
                 input virt_addr, output ready);
endinterface

/* rtl/sv39w_rsp_if.sv */
// Response channel interface: valid/ready handshake with translation result item.
// Depends on nothing.
`timescale 1ns / 1ps

interface sv39w_rsp_if;
   logic        valid;
   logic        ready;
   logic [55:0] phys_addr;
   logic [2:0]  status;

   modport source (output valid, output phys_addr, output status, input ready);
   modport sink (input valid, input phys_addr, input status, output ready);
endinterface

/* rtl/sv39_page_table_walker_unit.sv */
// Top level of the Sv39 page table walker: root page register, table store,
// walk sequencer and result register. Depends on sv39w_pkg, interfaces and submodules.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------------------
//  req_chan | in        | valid / ready      | action, word_index, word_data, virt_addr
//  rsp_chan | out       | valid / ready      | phys_addr, status
//  csr      | in        | csr_we             | csr_wdata (root page)
//
//  A write item or an early fault ends in the cycle it is taken; a full walk is paced by
//  three dependent reads of the single-read-port table store, one per level.
//  After reset the store is zeroed one word a cycle, with ready low until it is done.
//  A result waits in the output register while the next item is taken; a result that
//  finds the register still full is held in the walker, which then takes no item.
`timescale 1ns / 1ps

module sv39_page_table_walker_unit #(
   parameter int unsigned TABLE_WORDS = 4096
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [sv39w_pkg::ROOT_W-1:0] csr_wdata,
   sv39w_req_if.sink                    req_chan,
   sv39w_rsp_if.source                  rsp_chan
);
   import sv39w_pkg::*;

   localparam int unsigned AW = $clog2(TABLE_WORDS);

   logic [ROOT_W-1:0] root_ff, root_in;
   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [WORD_W-1:0] mem_wdata;
   logic [AW-1:0]     mem_raddr;
   logic [WORD_W-1:0] mem_rdata;
   logic              out_free;
   logic              fin_valid;
   result_type        fin;

   always_comb begin
      root_in = csr_we ? csr_wdata : root_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff <= '0;
      end else begin
         root_ff <= root_in;
      end
   end

   sv39w_ram #(
      .WIDTH (WORD_W),
      .DEPTH (TABLE_WORDS)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   sv39w_walk #(
      .TABLE_WORDS (TABLE_WORDS)
   ) u_walk (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .root_page (root_ff),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata),
      .out_free  (out_free),
      .fin_valid (fin_valid),
      .fin       (fin)
   );

   sv39w_rsp_stage u_rsp (
      .clock     (clock),
      .reset     (reset),
      .fin_valid (fin_valid),
      .fin       (fin),
      .out_free  (out_free),
      .rsp       (rsp_chan)
   );

endmodule

/* rtl/sv39w_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module sv39w_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/sv39w_rsp_stage.sv */
// Output register for result items; frees the walker while a result waits.
// Depends on sv39w_pkg and sv39w_rsp_if.
`timescale 1ns / 1ps

module sv39w_rsp_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fin_valid,
   input  sv39w_pkg::result_type  fin,
   output logic                   out_free,
   sv39w_rsp_if.source            rsp
);
   import sv39w_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff, data_in;

   always_comb begin
      out_free = !valid_ff || rsp.ready;
      valid_in = valid_ff;
      data_in  = data_ff;
      if (fin_valid && out_free) begin
         valid_in = 1'b1;
         data_in  = fin;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp.valid     = valid_ff;
   assign rsp.phys_addr = data_ff.phys_addr;
   assign rsp.status    = data_ff.status;

endmodule

/* rtl/sv39w_walk.sv */
// Walk sequencer: store clearing pass, word writes and the three-level table walk.
// Depends on sv39w_pkg, sv39w_req_if and the assertion macro header.
`timescale 1ns / 1ps
`include "sv39_page_table_walker_unit_defines.svh"

module sv39w_walk #(
   parameter int unsigned TABLE_WORDS = 4096
) (
   input  logic                           clock,
   input  logic                           reset,
   sv39w_req_if.sink                      req,
   input  logic [sv39w_pkg::ROOT_W-1:0]   root_page,
   output logic                           mem_we,
   output logic [$clog2(TABLE_WORDS)-1:0] mem_waddr,
   output logic [sv39w_pkg::WORD_W-1:0]   mem_wdata,
   output logic [$clog2(TABLE_WORDS)-1:0] mem_raddr,
   input  logic [sv39w_pkg::WORD_W-1:0]   mem_rdata,
   input  logic                           out_free,
   output logic                           fin_valid,
   output sv39w_pkg::result_type          fin
);
   import sv39w_pkg::*;

   localparam int unsigned AW = $clog2(TABLE_WORDS);
   localparam logic [AW-1:0] LAST_WORD = AW'(TABLE_WORDS - 1);
   localparam logic [PPN_W-1:0] STORE_PAGES = PPN_W'(TABLE_WORDS / PAGE_WORDS);
   localparam logic [20:0] WORDS_EXT = 21'(TABLE_WORDS);
   localparam int unsigned VA_KEEP = 30;

   walk_state_type     state_ff, state_in;
   logic [AW-1:0]      clr_ff, clr_in;
   logic [VA_KEEP-1:0] va_ff, va_in;
   result_type         hold_ff, hold_in;
   logic [PPN_W-1:0]   ppn;
   logic [PPN_W-1:0]   root_ext;
   logic [20:0]        widx_ext;

   function automatic logic [AW-1:0] tbl_addr(input logic [PPN_W-1:0] page,
                                               input logic [IDX_W-1:0] idx);
      logic [PPN_W+IDX_W-1:0] full;
      full = {page, idx};
      return full[AW-1:0];
   endfunction

   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      va_in      = va_ff;
      hold_in    = hold_ff;
      req.ready  = 1'b0;
      mem_we     = 1'b0;
      mem_waddr  = clr_ff;
      mem_wdata  = '0;
      mem_raddr  = '0;
      fin_valid  = 1'b0;
      fin        = '{phys_addr: '0, status: ST_OK};
      ppn        = mem_rdata[PPN_LSB +: PPN_W];
      root_ext   = PPN_W'(root_page);
      widx_ext   = 21'(req.word_index);

      case (state_ff)
         WS_CLEAR: begin
            mem_we = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == LAST_WORD) begin
               state_in = WS_IDLE;
            end
         end
         WS_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               if (req.action == ACT_WRITE) begin
                  mem_we    = widx_ext < WORDS_EXT;
                  mem_waddr = widx_ext[AW-1:0];
                  mem_wdata = req.word_data;
                  fin_valid = 1'b1;
               end else if (req.virt_addr[63:38] != '0) begin
                  fin_valid  = 1'b1;
                  fin.status = ST_LIMIT;
               end else if (root_ext >= STORE_PAGES) begin
                  fin_valid  = 1'b1;
                  fin.status = ST_OUTSIDE;
               end else begin
                  mem_raddr = tbl_addr(root_ext, req.virt_addr[38:30]);
                  va_in     = req.virt_addr[VA_KEEP-1:0];
                  state_in  = WS_L2;
               end
            end
         end
         WS_L2, WS_L1: begin
            if (!mem_rdata[PTE_V]) begin
               fin_valid  = 1'b1;
               fin.status = ST_UPPER;
            end else if (ppn >= STORE_PAGES) begin
               fin_valid  = 1'b1;
               fin.status = ST_OUTSIDE;
            end else if (state_ff == WS_L2) begin
               mem_raddr = tbl_addr(ppn, va_ff[29:21]);
               state_in  = WS_L1;
            end else begin
               mem_raddr = tbl_addr(ppn, va_ff[20:12]);
               state_in  = WS_L0;
            end
         end
         WS_L0: begin
            fin_valid = 1'b1;
            if (!mem_rdata[PTE_V]) begin
               fin.status = ST_LEAF;
            end else if (!mem_rdata[PTE_U]) begin
               fin.status = ST_USER;
            end else begin
               fin.phys_addr = {ppn, va_ff[PAGE_W-1:0]};
            end
         end
         WS_HOLD: begin
            fin_valid = 1'b1;
            fin       = hold_ff;
         end
         default: begin
            state_in = WS_IDLE;
         end
      endcase

      if (fin_valid) begin
         hold_in  = fin;
         state_in = out_free ? WS_IDLE : WS_HOLD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= WS_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
      va_ff   <= va_in;
      hold_ff <= hold_in;
   end

   `SV39W_ASSERT_NOW(a_no_write_in_walk, state_ff == WS_L2 || state_ff == WS_L1 || state_ff == WS_L0, !mem_we, "store written during a walk")
   `SV39W_ASSERT_NOW(a_no_result_in_clear, state_ff == WS_CLEAR, !fin_valid && !req.ready, "item activity during clearing pass")
   `SV39W_ASSERT_NEXT(a_hold_on_busy, fin_valid && !out_free, state_ff == WS_HOLD, "finished result not held")
   `SV39W_ASSERT_NEXT(a_l2_advance, state_ff == WS_L2, state_ff == WS_L1 || state_ff == WS_IDLE || state_ff == WS_HOLD, "bad step after level two read")

endmodule

/* tb/sv/sv39w_walk_checker.sv */
// Checker for the Sv39 page table walker: watches both channels and the root page
// register, walks its own copy of the table store and compares every result item.
// Depends on sv39w_pkg and the request and response interfaces.
`timescale 1ns / 1ps

module sv39w_walk_checker #(
   parameter int unsigned TABLE_WORDS = 4096
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [sv39w_pkg::ROOT_W-1:0] csr_wdata,
   sv39w_req_if                         req_mon,
   sv39w_rsp_if                         rsp_mon,
   output int                           fail_count,
   output int                           pending_count
);
   import sv39w_pkg::*;

   localparam int unsigned AW = $clog2(TABLE_WORDS);
   localparam int unsigned STORE_PAGES = TABLE_WORDS / PAGE_WORDS;
   localparam logic [WORD_W-1:0] VA_LIMIT = 64'd1 << 38;

   logic [WORD_W-1:0] page_words [TABLE_WORDS];
   logic [ROOT_W-1:0] root_pg;
   result_type        translations_due [$];

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      if (fail_count < 100) begin
         $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
      end
      fail_count++;
   endtask

   function automatic result_type walk_sv39(logic [WORD_W-1:0] va);
      result_type        res;
      logic [WORD_W-1:0] pg;
      logic [WORD_W-1:0] pte;
      logic [AW-1:0]     slot;
      int                lvl;
      res.phys_addr = '0;
      res.status = ST_OK;
      if (va >= VA_LIMIT) begin
         res.status = ST_LIMIT;
         return res;
      end
      pg = 64'(root_pg);
      pte = '0;
      for (lvl = 2; lvl >= 0; lvl--) begin
         if (pg >= STORE_PAGES) begin
            res.status = ST_OUTSIDE;
            return res;
         end
         slot = AW'(pg * PAGE_WORDS + va[PAGE_W + IDX_W * lvl +: IDX_W]);
         pte = page_words[slot];
         if (!pte[PTE_V]) begin
            res.status = (lvl == 0) ? ST_LEAF : ST_UPPER;
            return res;
         end
         pg = {20'd0, pte[PPN_LSB +: PPN_W]};
      end
      if (!pte[PTE_U]) begin
         res.status = ST_USER;
         return res;
      end
      res.phys_addr = {pte[PPN_LSB +: PPN_W], va[PAGE_W-1:0]};
      return res;
   endfunction

   always @(posedge clock) begin : watch
      result_type due;
      if (reset) begin
         for (int i = 0; i < TABLE_WORDS; i++) begin
            page_words[i] = '0;
         end
         root_pg = '0;
         fail_count = 0;
         translations_due.delete();
      end else begin
         if (csr_we) begin
            root_pg = csr_wdata;
         end
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.action == ACT_WRITE) begin
               if (req_mon.word_index < TABLE_WORDS) begin
                  page_words[AW'(req_mon.word_index)] = req_mon.word_data;
               end
               due.phys_addr = '0;
               due.status = ST_OK;
               translations_due.push_back(due);
            end else begin
               translations_due.push_back(walk_sv39(req_mon.virt_addr));
            end
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (translations_due.size() == 0) begin
               report_mismatch("unrequested item", {8'd0, rsp_mon.phys_addr},
                               {61'd0, rsp_mon.status});
            end else begin
               due = translations_due.pop_front();
               if (rsp_mon.phys_addr !== due.phys_addr) begin
                  report_mismatch("phys_addr", {8'd0, rsp_mon.phys_addr},
                                  {8'd0, due.phys_addr});
               end
               if (rsp_mon.status !== due.status) begin
                  report_mismatch("status", {61'd0, rsp_mon.status}, {61'd0, due.status});
               end
            end
         end
      end
      pending_count <= translations_due.size();
   end

endmodule

/* tb/sv/tb.sv */
// Testbench top for the Sv39 page table walker: clock, reset, root page writes,
// table loads and translations with random gaps and stalls, watchdog and verdict.
// Depends on sv39w_pkg, the interfaces, the walker unit and sv39w_walk_checker.
`timescale 1ns / 1ps

module tb;
   import sv39w_pkg::*;

   localparam int unsigned TABLE_WORDS = 4096;
   localparam int unsigned STALL_LIMIT = 12000;
   localparam int unsigned ITEM_TARGET = 1000;
   localparam int unsigned PHASES      = 7;
   localparam int unsigned LONG_HOLD   = 300;
   localparam logic [63:0] VA_LIMIT    = 64'd1 << 38;

   typedef enum int {
      BREAK_L2,
      BREAK_L1,
      BREAK_LEAF,
      BREAK_USER,
      BREAK_OUTSIDE
   } walk_break_type;

   logic              clock;
   logic              reset;
   logic              csr_we;
   logic [ROOT_W-1:0] csr_wdata;
   int                fail_count;
   int                pending_count;
   int unsigned       items_sent;
   int unsigned       idle_cycles;
   logic [ROOT_W-1:0] root_now;
   int unsigned       hold_requests;
   bit                send_calm;

   sv39w_req_if req_chan ();
   sv39w_rsp_if rsp_chan ();

   sv39_page_table_walker_unit #(
      .TABLE_WORDS(TABLE_WORDS)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_wdata(csr_wdata),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   sv39w_walk_checker #(
      .TABLE_WORDS(TABLE_WORDS)
   ) u_checker (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .req_mon      (req_chan),
      .rsp_mon      (rsp_chan),
      .fail_count   (fail_count),
      .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_chan.valid && req_chan.ready)
             || (rsp_chan.valid && rsp_chan.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("CHECK FAILED");
      $finish;
   end

   initial begin : rsp_side
      int unsigned wait_cycles;
      int unsigned holds_done;
      bit          calm;
      calm = 0;
      holds_done = 0;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if ($urandom_range(0, 15) == 0) begin
            calm = !calm;
         end
         wait_cycles = calm ? 0 : $urandom_range(0, 14);
         if (hold_requests != holds_done) begin
            holds_done++;
            wait_cycles = LONG_HOLD;
         end
         if (wait_cycles > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_chan.valid && rsp_chan.ready));
      end
   end

   task automatic send_item(logic act, logic [11:0] idx, logic [63:0] data, logic [63:0] va);
      int unsigned gap;
      if ($urandom_range(0, 15) == 0) begin
         send_calm = !send_calm;
      end
      gap = send_calm ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.action     <= act;
      req_chan.word_index <= idx;
      req_chan.word_data  <= data;
      req_chan.virt_addr  <= va;
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
      items_sent++;
   endtask

   task automatic write_word(logic [11:0] idx, logic [63:0] data);
      send_item(ACT_WRITE, idx, data, {$urandom, $urandom});
   endtask

   task automatic translate(logic [63:0] va);
      send_item(ACT_TRANSLATE, 12'($urandom), {$urandom, $urandom}, va);
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   task automatic write_root(logic [ROOT_W-1:0] value);
      csr_wdata <= value;
      csr_we    <= 1'b1;
      @(posedge clock);
      csr_we    <= 1'b0;
      root_now = value;
   endtask

   function automatic logic [63:0] make_pte(logic [43:0] ppn, logic v, logic u);
      logic [63:0] w;
      w = {$urandom, $urandom};
      w[PPN_LSB +: PPN_W] = ppn;
      w[PTE_V] = v;
      w[PTE_U] = u;
      return w;
   endfunction

   function automatic logic [43:0] outside_ppn();
      logic [43:0] p;
      p = ($urandom_range(0, 1) == 0) ? 44'($urandom_range(8, 15))
                                      : 44'({$urandom, $urandom});
      if (p < 8) begin
         p = p + 44'd8;
      end
      return p;
   endfunction

   task automatic walk_sequence(bit broken);
      logic [63:0]    va;
      logic [43:0]    p1;
      logic [43:0]    p0;
      logic [43:0]    leaf;
      logic           v2;
      logic           v1;
      logic           v0;
      logic           u0;
      walk_break_type kind;
      int unsigned    extra;
      va = {$urandom, $urandom} & (VA_LIMIT - 1);
      p1 = 44'($urandom_range(0, 7));
      p0 = 44'($urandom_range(0, 7));
      leaf = ($urandom_range(0, 7) == 0) ? 44'd0 : 44'({$urandom, $urandom});
      v2 = 1'b1;
      v1 = 1'b1;
      v0 = 1'b1;
      u0 = 1'b1;
      if (broken) begin
         kind = walk_break_type'($urandom_range(0, 4));
         case (kind)
            BREAK_L2: v2 = 1'b0;
            BREAK_L1: v1 = 1'b0;
            BREAK_LEAF: v0 = 1'b0;
            BREAK_USER: u0 = 1'b0;
            default: begin
               if ($urandom_range(0, 1) == 0) begin
                  p1 = outside_ppn();
               end else begin
                  p0 = outside_ppn();
               end
            end
         endcase
      end
      write_word({root_now, va[38:30]}, make_pte(p1, v2, 1'($urandom_range(0, 1))));
      write_word({p1[2:0], va[29:21]}, make_pte(p0, v1, 1'($urandom_range(0, 1))));
      write_word({p0[2:0], va[20:12]}, make_pte(leaf, v0, u0));
      translate(va);
      extra = $urandom_range(0, 2);
      repeat (extra) translate({va[63:12], 12'($urandom)});
   endtask

   task automatic noise_item();
      if ($urandom_range(0, 1) == 0) begin
         write_word(12'($urandom), {$urandom, $urandom});
      end else if ($urandom_range(0, 1) == 0) begin
         translate({$urandom, $urandom});
      end else begin
         translate({$urandom, $urandom} & (VA_LIMIT - 1));
      end
   endtask

   task automatic random_phase(int unsigned stop_at);
      int unsigned pick;
      while (items_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            walk_sequence(1'b0);
         end else if (pick < 85) begin
            walk_sequence(1'b1);
         end else begin
            noise_item();
         end
      end
   endtask

   initial begin : stimulus
      logic [ROOT_W-1:0] phase_roots [PHASES];
      int unsigned       directed_end;
      reset               <= 1'b1;
      csr_we              <= 1'b0;
      csr_wdata           <= '0;
      req_chan.valid      <= 1'b0;
      req_chan.action     <= ACT_WRITE;
      req_chan.word_index <= '0;
      req_chan.word_data  <= '0;
      req_chan.virt_addr  <= '0;
      hold_requests = 0;
      send_calm = 0;
      items_sent = 0;
      root_now = '0;
      phase_roots[0] = 3'd7;
      phase_roots[1] = 3'd3;
      phase_roots[2] = 3'd0;
      phase_roots[3] = ROOT_W'($urandom_range(0, 7));
      phase_roots[4] = 3'd5;
      phase_roots[5] = ROOT_W'($urandom_range(0, 7));
      phase_roots[6] = 3'd7;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      write_root(3'd0);

      translate(64'd0);
      translate(VA_LIMIT);
      translate(64'hFFFF_FFFF_FFFF_FFFF);
      // pointer with R/W/X set, then leaf on page zero
      write_word(12'd0, 64'h0000_0000_0000_040F);
      write_word(12'd512, 64'h0000_0000_0000_0801);
      write_word(12'd1024, 64'h0000_0000_0000_0011);
      translate(64'h0000_0000_0000_0123);
      write_word(12'd1024, 64'hFFFF_FFFF_FFFF_FFFF);
      translate(64'h0000_0000_0000_0FFF);
      write_word(12'd1024, 64'h0000_0000_0000_0C01);
      translate(64'h0000_0000_0000_0007);
      write_word(12'd1024, 64'h0000_0000_0000_0010);
      translate(64'h0000_0000_0000_0800);
      write_word(12'd512, 64'h0000_0000_0000_2001);
      translate(64'h0000_0000_0000_0456);
      write_word(12'd512, 64'h0000_0000_0000_0000);
      translate(64'h0000_0000_0000_0789);
      write_word(12'd511, 64'h0000_0000_0000_1C01);
      write_word(12'd4095, 64'hFFFF_FFFF_FFFF_FFFF);
      translate(VA_LIMIT - 1);
      write_word(12'd0, 64'h0000_0000_0000_0000);
      directed_end = items_sent;

      for (int ph = 0; ph < PHASES; ph++) begin
         wait_drained();
         write_root(phase_roots[ph]);
         if (ph == 1) begin
            hold_requests++;
         end
         random_phase(directed_end + (ph + 1) * ITEM_TARGET / PHASES);
      end
      wait_drained();
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
